// ===== design/eirc_pkg.sv =====
`timescale 1ns / 1ps

package eirc_pkg;

	localparam int MAX_FRAME = 1536;
	localparam int CNT_W     = $clog2(MAX_FRAME + 1);
	localparam int LEN_W     = 11;

	localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP     = 8'd1;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [15:0] PORT_DHCP      = 16'd68;

	localparam int ETH_HDR_LEN  = 14;
	localparam int MIN_ARP_LEN  = 42;
	localparam int MIN_IPV4_LEN = 34;
	localparam int MIN_UDP_LEN  = 42;
	localparam int MIN_IHL      = 20;

	localparam int POS_ETYPE_HI = 12;
	localparam int POS_ETYPE_LO = 13;
	localparam int POS_IHL      = 14;
	localparam int POS_TLEN_HI  = 16;
	localparam int POS_TLEN_LO  = 17;
	localparam int POS_PROTO    = 23;
	localparam int POS_DPORT_HI = 36;
	localparam int POS_DPORT_LO = 37;

	localparam logic [2:0] VERDICT_DROP = 3'd0;
	localparam logic [2:0] VERDICT_ARP  = 3'd1;
	localparam logic [2:0] VERDICT_TCP  = 3'd2;
	localparam logic [2:0] VERDICT_ICMP = 3'd3;
	localparam logic [2:0] VERDICT_DHCP = 3'd4;
	localparam logic [2:0] VERDICT_DNS  = 3'd5;

	typedef struct packed {
		logic [CNT_W-1:0] byte_count;
		logic [15:0]      ether_type;
		logic [3:0]       header_words;
		logic [16:0]      sum_acc;
		logic [7:0]       pending_high;
		logic [15:0]      ip_length;
		logic [7:0]       protocol;
		logic [15:0]      dest_port;
	} frame_state_t;

endpackage

// ===== design/eirc_parser.sv =====
`timescale 1ns / 1ps

module eirc_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic [7:0]              frame_byte_s1,
	input  logic                    last_byte_s1,
	output eirc_pkg::frame_state_t  next_state
);

	eirc_pkg::frame_state_t st_q;
	eirc_pkg::frame_state_t nxt;
	logic [eirc_pkg::CNT_W-1:0] pos;
	logic [3:0]                 hw_eff;
	logic [6:0]                 hdr_end;
	logic [17:0]                sum_raw;
	logic [16:0]                sum_fold;

	always_comb begin
		nxt      = st_q;
		pos      = st_q.byte_count;
		hw_eff   = (pos == eirc_pkg::CNT_W'(eirc_pkg::POS_IHL)) ? frame_byte_s1[3:0]
			: st_q.header_words;
		hdr_end  = 7'(eirc_pkg::ETH_HDR_LEN) + {1'b0, hw_eff, 2'b00};
		sum_raw  = {1'b0, st_q.sum_acc} + {2'b00, st_q.pending_high, frame_byte_s1};
		sum_fold = {1'b0, sum_raw[15:0]} + {15'd0, sum_raw[17:16]};
		if (st_q.byte_count < eirc_pkg::CNT_W'(eirc_pkg::MAX_FRAME)) begin
			if (pos == eirc_pkg::CNT_W'(eirc_pkg::POS_ETYPE_HI))
				nxt.ether_type[15:8] = frame_byte_s1;
			if (pos == eirc_pkg::CNT_W'(eirc_pkg::POS_ETYPE_LO))
				nxt.ether_type[7:0] = frame_byte_s1;
			nxt.header_words = hw_eff;
			if (pos == eirc_pkg::CNT_W'(eirc_pkg::POS_TLEN_HI))
				nxt.ip_length[15:8] = frame_byte_s1;
			if (pos == eirc_pkg::CNT_W'(eirc_pkg::POS_TLEN_LO))
				nxt.ip_length[7:0] = frame_byte_s1;
			if (pos == eirc_pkg::CNT_W'(eirc_pkg::POS_PROTO))
				nxt.protocol = frame_byte_s1;
			if (pos == eirc_pkg::CNT_W'(eirc_pkg::POS_DPORT_HI))
				nxt.dest_port[15:8] = frame_byte_s1;
			if (pos == eirc_pkg::CNT_W'(eirc_pkg::POS_DPORT_LO))
				nxt.dest_port[7:0] = frame_byte_s1;
			if (pos >= eirc_pkg::CNT_W'(eirc_pkg::ETH_HDR_LEN)
					&& pos < eirc_pkg::CNT_W'(hdr_end)) begin
				if (!pos[0]) begin
					nxt.pending_high = frame_byte_s1;
				end else begin
					nxt.sum_acc = sum_fold;
				end
			end
			nxt.byte_count = st_q.byte_count + 1'b1;
		end
	end

	assign next_state = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (take) begin
			st_q <= last_byte_s1 ? '0 : nxt;
		end
	end

endmodule

// ===== design/eirc_decide.sv =====
`timescale 1ns / 1ps

module eirc_decide (
	input  eirc_pkg::frame_state_t st,
	input  logic [15:0]            dns_port,
	output logic [2:0]             verdict
);

	logic [16:0] len;
	logic [16:0] ihl;
	logic [16:0] ip_len;

	always_comb begin
		len     = 17'(st.byte_count);
		ihl     = {11'd0, st.header_words, 2'b00};
		ip_len  = {1'b0, st.ip_length};
		verdict = eirc_pkg::VERDICT_DROP;
		priority if (len < 17'(eirc_pkg::ETH_HDR_LEN)) begin
			verdict = eirc_pkg::VERDICT_DROP;
		end else if (st.ether_type == eirc_pkg::ETHERTYPE_ARP) begin
			if (len >= 17'(eirc_pkg::MIN_ARP_LEN))
				verdict = eirc_pkg::VERDICT_ARP;
		end else if (st.ether_type != eirc_pkg::ETHERTYPE_IPV4
				|| len < 17'(eirc_pkg::MIN_IPV4_LEN)) begin
			verdict = eirc_pkg::VERDICT_DROP;
		end else if (ihl < 17'(eirc_pkg::MIN_IHL)
				|| 17'(eirc_pkg::ETH_HDR_LEN) + ihl > len) begin
			verdict = eirc_pkg::VERDICT_DROP;
		end else if (st.sum_acc[15:0] != 16'hFFFF) begin
			verdict = eirc_pkg::VERDICT_DROP;
		end else if (ip_len < ihl || 17'(eirc_pkg::ETH_HDR_LEN) + ip_len > len) begin
			verdict = eirc_pkg::VERDICT_DROP;
		end else if (st.protocol == eirc_pkg::PROTO_TCP) begin
			verdict = eirc_pkg::VERDICT_TCP;
		end else if (st.protocol == eirc_pkg::PROTO_ICMP) begin
			verdict = eirc_pkg::VERDICT_ICMP;
		end else if (st.protocol == eirc_pkg::PROTO_UDP
				&& len >= 17'(eirc_pkg::MIN_UDP_LEN)) begin
			if (st.dest_port == eirc_pkg::PORT_DHCP)
				verdict = eirc_pkg::VERDICT_DHCP;
			else if (dns_port != 16'd0 && st.dest_port == dns_port)
				verdict = eirc_pkg::VERDICT_DNS;
		end else begin
			verdict = eirc_pkg::VERDICT_DROP;
		end
	end

endmodule

// ===== design/ethernet_ipv4_rx_classifier_unit.sv =====
`timescale 1ns / 1ps

// Receive classifier for Ethernet frames carrying ARP or IPv4. It takes one frame byte
// per clock while frame_stall is low, with no gaps required. Each byte passes once
// through the input register and the header parser; for the byte marked last the
// verdict logic then loads one verdict and the saturated frame length into the result
// register. A result waiting on a stalled output holds back only the next byte marked
// last, which then waits in the input register and stalls the input.

module ethernet_ipv4_rx_classifier_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [15:0] cfg_write_data,
	input  logic        frame_valid,
	output logic        frame_stall,
	input  logic [7:0]  frame_byte,
	input  logic        last_byte,
	output logic        verdict_valid,
	input  logic        verdict_stall,
	output logic [2:0]  verdict,
	output logic [10:0] frame_length
);

	logic                   valid_s1;
	logic [7:0]             frame_byte_s1;
	logic                   last_byte_s1;
	logic                   valid_s2;
	logic [2:0]             verdict_s2;
	logic [10:0]            frame_length_s2;
	logic [15:0]            dns_port_q;
	logic                   accept;
	logic                   advance;
	logic [2:0]             verdict_next;
	eirc_pkg::frame_state_t next_state;

	assign advance     = valid_s1 && (!last_byte_s1 || !valid_s2 || !verdict_stall);
	assign frame_stall = valid_s1 && !advance;
	assign accept      = frame_valid && !frame_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dns_port_q <= '0;
		end else if (cfg_write_en) begin
			dns_port_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_byte_s1 <= frame_byte;
			last_byte_s1  <= last_byte;
		end
	end

	eirc_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (advance),
		.frame_byte_s1 (frame_byte_s1),
		.last_byte_s1  (last_byte_s1),
		.next_state    (next_state)
	);

	eirc_decide u_decide (
		.st       (next_state),
		.dns_port (dns_port_q),
		.verdict  (verdict_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && last_byte_s1) begin
			valid_s2 <= 1'b1;
		end else if (!verdict_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_byte_s1) begin
			verdict_s2      <= verdict_next;
			frame_length_s2 <= next_state.byte_count[eirc_pkg::LEN_W-1:0];
		end
	end

	assign verdict_valid = valid_s2;
	assign verdict       = verdict_s2;
	assign frame_length  = frame_length_s2;

endmodule

// ===== design/eirc_checker.sv =====
`timescale 1ns / 1ps

module eirc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        frame_stall,
	input logic        verdict_valid,
	input logic        verdict_stall,
	input logic [2:0]  verdict,
	input logic [10:0] frame_length
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && verdict_stall |=> verdict_valid && $stable(verdict)
			&& $stable(frame_length))
		else $error("Stalled verdict changed before its transfer.");

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!verdict_valid |-> !frame_stall)
		else $error("Input stalled while the result register was empty.");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> verdict <= eirc_pkg::VERDICT_DNS
			&& 32'(frame_length) <= eirc_pkg::MAX_FRAME)
		else $error("Verdict code or frame length out of range.");

	a_class_min_len: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && (verdict == eirc_pkg::VERDICT_ARP
			|| verdict == eirc_pkg::VERDICT_DHCP || verdict == eirc_pkg::VERDICT_DNS)
		|-> 32'(frame_length) >= eirc_pkg::MIN_ARP_LEN)
		else $error("ARP or UDP class given for a short frame.");

	a_ip_min_len: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && (verdict == eirc_pkg::VERDICT_TCP
			|| verdict == eirc_pkg::VERDICT_ICMP)
		|-> 32'(frame_length) >= eirc_pkg::MIN_IPV4_LEN)
		else $error("IPv4 class given for a short frame.");

endmodule

bind ethernet_ipv4_rx_classifier_unit eirc_checker u_eirc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.frame_stall   (frame_stall),
	.verdict_valid (verdict_valid),
	.verdict_stall (verdict_stall),
	.verdict       (verdict),
	.frame_length  (frame_length)
);
